@@ src/sqfc_pkg.sv @@
// Package for the squarefree composite tester: widths, FSM state type.
// No dependencies; used by sqfc_div, squarefree_composite_test and sqfc_checker.
`timescale 1ns / 1ps

package sqfc_pkg;

    // Width of the tested value
    localparam int VALUE_BITS = 40;
    // Width of tdata on the input side, padded to whole bytes
    localparam int IN_DATA_BITS = ((VALUE_BITS + 7) / 8) * 8;
    // Trial divisor width: candidates stay near sqrt of the value
    localparam int DIV_BITS = VALUE_BITS / 2 + 2;
    // Width of the running square of the candidate
    localparam int SQ_BITS = VALUE_BITS + 2;
    // Step counter of the bit-serial divider
    localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

    // Control sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV1,
        ST_DIV2,
        ST_OUT
    } state_t;

endpackage

@@ src/squarefree_composite_test.sv @@
// Top level of the squarefree composite tester: stream ports and sequencer.
// Depends on sqfc_pkg and sqfc_div.
`timescale 1ns / 1ps

// Tests one unsigned 40-bit word per run and returns 1 when it is a product of
// two or more distinct primes. Even inputs lose one factor 2 on entry (a second
// 2 ends the run at once); then odd candidates 3, 5, 7, ... are tried while the
// candidate squared does not exceed the remaining value. Every trial is a bound
// check and one pass of a bit-serial divider, and each factor found takes a
// second pass to test for a repeat. The worst case is a prime near 2^40:
// about 2^19 candidates. One word is in flight at a time; the input is ready
// only while the block is idle, and the result word waits in the output
// register until taken.

module squarefree_composite_test (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: [39:0] value; at this width there are no padding bits
    input  logic [sqfc_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // tdata: [0] is_squarefree_composite, [7:1] zero
    output logic [7:0]                           m_axis_tdata
);

    sqfc_pkg::state_t                  state_reg, state_next;
    logic [sqfc_pkg::VALUE_BITS-1:0]   rem_reg, rem_next;
    logic [sqfc_pkg::DIV_BITS-1:0]     cand_reg, cand_next;
    logic [sqfc_pkg::SQ_BITS-1:0]      sq_reg, sq_next;
    logic [1:0]                        found_reg, found_next;
    logic                              result_reg, result_next;

    logic [sqfc_pkg::VALUE_BITS-1:0]   in_value;
    logic                              div_start;
    logic [sqfc_pkg::VALUE_BITS-1:0]   div_dividend;
    logic                              div_done;
    logic [sqfc_pkg::VALUE_BITS-1:0]   div_quot;
    logic [sqfc_pkg::DIV_BITS-1:0]     div_rem;
    logic [sqfc_pkg::SQ_BITS-1:0]      sq_step;
    logic                              past_bound;
    logic                              final_result;

    assign in_value = s_axis_tdata[sqfc_pkg::VALUE_BITS-1:0];

    // (c+2)^2 = c^2 + 4c + 4
    assign sq_step = sq_reg + sqfc_pkg::SQ_BITS'({cand_reg, 2'b00})
                   + sqfc_pkg::SQ_BITS'(4);
    assign past_bound = (sq_reg > sqfc_pkg::SQ_BITS'(rem_reg));

    // No factor, or a single factor with nothing left over: not composite
    assign final_result = !((found_reg == 2'd0) ||
                            ((found_reg == 2'd1) && (rem_reg == sqfc_pkg::VALUE_BITS'(1))));

    sqfc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (cand_reg),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // Sequencer: next state and datapath updates
    always_comb
    begin
        state_next   = state_reg;
        rem_next     = rem_reg;
        cand_next    = cand_reg;
        sq_next      = sq_reg;
        found_next   = found_reg;
        result_next  = result_reg;
        div_start    = 1'b0;
        div_dividend = rem_reg;

        case (state_reg)
            sqfc_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cand_next = sqfc_pkg::DIV_BITS'(3);
                    sq_next   = sqfc_pkg::SQ_BITS'(9);
                    if (in_value[0])
                    begin
                        rem_next   = in_value;
                        found_next = 2'd0;
                        state_next = sqfc_pkg::ST_CHECK;
                    end
                    else
                    begin
                        rem_next   = in_value >> 1;
                        found_next = 2'd1;
                        if (!in_value[1])
                        begin
                            // divisible by four (or zero)
                            result_next = 1'b0;
                            state_next  = sqfc_pkg::ST_OUT;
                        end
                        else
                        begin
                            state_next = sqfc_pkg::ST_CHECK;
                        end
                    end
                end
            end

            sqfc_pkg::ST_CHECK:
            begin
                if (past_bound)
                begin
                    result_next = final_result;
                    state_next  = sqfc_pkg::ST_OUT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = sqfc_pkg::ST_DIV1;
                end
            end

            sqfc_pkg::ST_DIV1:
            begin
                if (div_done)
                begin
                    if (div_rem == '0)
                    begin
                        // factor found: remove it, then test for a repeat
                        rem_next     = div_quot;
                        found_next   = (found_reg == 2'd2) ? 2'd2 : found_reg + 2'd1;
                        div_start    = 1'b1;
                        div_dividend = div_quot;
                        state_next   = sqfc_pkg::ST_DIV2;
                    end
                    else
                    begin
                        cand_next  = cand_reg + sqfc_pkg::DIV_BITS'(2);
                        sq_next    = sq_step;
                        state_next = sqfc_pkg::ST_CHECK;
                    end
                end
            end

            sqfc_pkg::ST_DIV2:
            begin
                if (div_done)
                begin
                    if (div_rem == '0)
                    begin
                        // repeated factor
                        result_next = 1'b0;
                        state_next  = sqfc_pkg::ST_OUT;
                    end
                    else
                    begin
                        cand_next  = cand_reg + sqfc_pkg::DIV_BITS'(2);
                        sq_next    = sq_step;
                        state_next = sqfc_pkg::ST_CHECK;
                    end
                end
            end

            sqfc_pkg::ST_OUT:
            begin
                if (m_axis_tready)
                    state_next = sqfc_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = sqfc_pkg::ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= sqfc_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        cand_reg   <= cand_next;
        sq_reg     <= sq_next;
        found_reg  <= found_next;
        result_reg <= result_next;
    end

    assign s_axis_tready = (state_reg == sqfc_pkg::ST_IDLE);
    assign m_axis_tvalid = (state_reg == sqfc_pkg::ST_OUT);
    assign m_axis_tdata  = {7'b0, result_reg};

endmodule

@@ src/sqfc_div.sv @@
// Bit-serial restoring divider: one quotient bit per clock.
// Depends on sqfc_pkg for VALUE_BITS, DIV_BITS and CNT_BITS.
`timescale 1ns / 1ps

module sqfc_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [sqfc_pkg::VALUE_BITS-1:0]   dividend,
    input  logic [sqfc_pkg::DIV_BITS-1:0]     divisor,
    output logic                              done,
    output logic [sqfc_pkg::VALUE_BITS-1:0]   quotient,
    output logic [sqfc_pkg::DIV_BITS-1:0]     remainder
);

    logic [sqfc_pkg::VALUE_BITS-1:0] q_reg, q_next;
    logic [sqfc_pkg::DIV_BITS-1:0]   r_reg, r_next;
    logic [sqfc_pkg::DIV_BITS-1:0]   d_reg, d_next;
    logic [sqfc_pkg::CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;

    logic [sqfc_pkg::DIV_BITS:0]     trial;
    logic [sqfc_pkg::DIV_BITS:0]     diff;
    logic                            fits;

    // One restoring step: shift in next dividend bit, subtract if it fits
    always_comb
    begin
        trial = {r_reg, q_reg[sqfc_pkg::VALUE_BITS-1]};
        fits  = (trial >= {1'b0, d_reg});
        diff  = trial - {1'b0, d_reg};

        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = sqfc_pkg::CNT_BITS'(sqfc_pkg::VALUE_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[sqfc_pkg::VALUE_BITS-2:0], fits};
            r_next   = fits ? diff[sqfc_pkg::DIV_BITS-1:0] : trial[sqfc_pkg::DIV_BITS-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == sqfc_pkg::CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath shift registers
    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

@@ src/sqfc_checker.sv @@
// Port-level checker for squarefree_composite_test, bound to the top level.
// Depends on sqfc_pkg for the input word width.
`timescale 1ns / 1ps

module sqfc_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    input  logic                                 s_axis_tready,
    input  logic [sqfc_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
    input  logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic [7:0]                           m_axis_tdata
);

    // One word in flight: never ready for input while a result is offered
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while result pending");

    // An accepted word closes the input side on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input still ready after accept");

    // A multiple of four (or zero) is answered with 0 on the next cycle
    a_by_four: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tdata[1:0] == 2'b00))
        |=> (m_axis_tvalid && !m_axis_tdata[0]))
        else $error("multiple of four not rejected at once");

    // Result word is a single flag bit
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:1] == 7'd0))
        else $error("result padding not zero");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed under stall");

endmodule

bind squarefree_composite_test sqfc_checker u_sqfc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
